/* src/irpdd_pkg.sv */
// Shared types, constants and register map of the IR pulse-distance decoder.
package irpdd_pkg;

	// Fixed field widths
	localparam int TICK_W   = 16;
	localparam int SCALE_W  = 8;
	localparam int BOUND_W  = 20;
	localparam int US_W     = TICK_W + SCALE_W;
	localparam int CODE_W   = 32;
	localparam int BITIDX_W = $clog2(CODE_W);
	localparam int MARK_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = BOUND_W;

	// Default frame shape
	localparam int CODE_BITS_DEF    = 32;
	localparam int LEADER_MARKS_DEF = 2;

	// Item kinds
	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_RESUME = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_US_PER_TICK = 3'd6;

	// Register reset values
	localparam logic [BOUND_W-1:0] SHORT_MIN_RST  = 20'd450;
	localparam logic [BOUND_W-1:0] SHORT_MAX_RST  = 20'd650;
	localparam logic [BOUND_W-1:0] MEDIUM_MIN_RST = 20'd1500;
	localparam logic [BOUND_W-1:0] MEDIUM_MAX_RST = 20'd1700;
	localparam logic [BOUND_W-1:0] LONG_MIN_RST   = 20'd4400;
	localparam logic [BOUND_W-1:0] LONG_MAX_RST   = 20'd4600;
	localparam logic [SCALE_W-1:0] US_PER_TICK_RST = 8'd16;

	typedef struct packed {
		logic [BOUND_W-1:0] short_min;
		logic [BOUND_W-1:0] short_max;
		logic [BOUND_W-1:0] medium_min;
		logic [BOUND_W-1:0] medium_max;
		logic [BOUND_W-1:0] long_min;
		logic [BOUND_W-1:0] long_max;
		logic [SCALE_W-1:0] us_per_tick;
	} cfg_t;

	typedef struct packed {
		logic is_short;
		logic is_medium;
		logic is_long;
	} class_t;

endpackage

/* src/irpdd_cfg.sv */
// Configuration register file: window bounds and tick scale.
module irpdd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [irpdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irpdd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output irpdd_pkg::cfg_t                  cfg
);
	import irpdd_pkg::*;

	cfg_t cfg_q;

	// Indexed write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min   <= SHORT_MIN_RST;
			cfg_q.short_max   <= SHORT_MAX_RST;
			cfg_q.medium_min  <= MEDIUM_MIN_RST;
			cfg_q.medium_max  <= MEDIUM_MAX_RST;
			cfg_q.long_min    <= LONG_MIN_RST;
			cfg_q.long_max    <= LONG_MAX_RST;
			cfg_q.us_per_tick <= US_PER_TICK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_MIN:   cfg_q.short_min   <= cfg_wdata;
				REG_SHORT_MAX:   cfg_q.short_max   <= cfg_wdata;
				REG_MEDIUM_MIN:  cfg_q.medium_min  <= cfg_wdata;
				REG_MEDIUM_MAX:  cfg_q.medium_max  <= cfg_wdata;
				REG_LONG_MIN:    cfg_q.long_min    <= cfg_wdata;
				REG_LONG_MAX:    cfg_q.long_max    <= cfg_wdata;
				REG_US_PER_TICK: cfg_q.us_per_tick <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/irpdd_classify.sv */
// Interval measurement and window classification for one edge.
module irpdd_classify (
	input  logic [irpdd_pkg::TICK_W-1:0] now_ticks,
	input  logic [irpdd_pkg::TICK_W-1:0] prev_ticks,
	input  irpdd_pkg::cfg_t              cfg,
	output irpdd_pkg::class_t            cls
);
	import irpdd_pkg::*;

	logic              huge;
	logic [TICK_W-1:0] diff;
	logic [US_W-1:0]   us;

	// Timer wrap between edges counts as an out-of-range interval
	assign huge = now_ticks < prev_ticks;
	assign diff = now_ticks - prev_ticks;
	assign us   = US_W'(diff) * US_W'(cfg.us_per_tick);

	// Exclusive-bound windows
	assign cls.is_short  = !huge && (us > US_W'(cfg.short_min))  && (us < US_W'(cfg.short_max));
	assign cls.is_medium = !huge && (us > US_W'(cfg.medium_min)) && (us < US_W'(cfg.medium_max));
	assign cls.is_long   = !huge && (us > US_W'(cfg.long_min))   && (us < US_W'(cfg.long_max));

endmodule

/* src/irpdd_frame.sv */
// Frame sequencer: mark counter, code word and previous timestamp.
module irpdd_frame #(
	parameter int CODE_BITS    = irpdd_pkg::CODE_BITS_DEF,
	parameter int LEADER_MARKS = irpdd_pkg::LEADER_MARKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic                         kind,
	input  logic [irpdd_pkg::TICK_W-1:0] edge_ticks,
	input  irpdd_pkg::cfg_t              cfg,
	output logic                         ready_d,
	output logic [irpdd_pkg::CODE_W-1:0] code_d
);
	import irpdd_pkg::*;

	localparam logic [MARK_W-1:0] LEADER_M = MARK_W'(LEADER_MARKS);
	localparam logic [MARK_W-1:0] FRAME_M  = MARK_W'(LEADER_MARKS + 2 * CODE_BITS);
	localparam logic [MARK_W-1:0] TOP_POS  = MARK_W'(CODE_BITS - 1);

	logic [MARK_W-1:0]   mark_q, mark_d;
	logic [CODE_W-1:0]   code_q;
	logic [TICK_W-1:0]   prev_q, prev_d;
	logic [MARK_W-1:0]   rel;
	logic [MARK_W-1:0]   pos_full;
	logic [BITIDX_W-1:0] bit_idx;
	class_t              cls;

	irpdd_classify u_classify (
		.now_ticks  (edge_ticks),
		.prev_ticks (prev_q),
		.cfg        (cfg),
		.cls        (cls)
	);

	// Data bit position, MSB first; rel is odd on data intervals
	assign rel      = mark_q - LEADER_M;
	assign pos_full = TOP_POS - {1'b0, rel[MARK_W-1:1]};
	assign bit_idx  = pos_full[BITIDX_W-1:0];

	// Next state
	always_comb begin
		mark_d = mark_q;
		code_d = code_q;
		prev_d = prev_q;
		if (go) begin
			if (kind == KIND_RESUME) begin
				mark_d = '0;
			end else if (mark_q != FRAME_M) begin
				prev_d = edge_ticks;
				if (mark_q < LEADER_M) begin
					mark_d = cls.is_long ? mark_q + MARK_W'(1) : '0;
				end else if (!rel[0]) begin
					mark_d = cls.is_short ? mark_q + MARK_W'(1) : '0;
				end else if (cls.is_short || cls.is_medium) begin
					code_d[bit_idx] = !cls.is_short;
					mark_d = mark_q + MARK_W'(1);
				end else begin
					mark_d = '0;
				end
			end
		end
	end

	assign ready_d = mark_d == FRAME_M;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
			code_q <= '0;
			prev_q <= '0;
		end else begin
			mark_q <= mark_d;
			code_q <= code_d;
			prev_q <= prev_d;
		end
	end

	// Counter never runs past a full frame
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= FRAME_M)
		else $error("mark count beyond frame length");

	// Resume always rearms
	a_resume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && kind == KIND_RESUME |=> mark_q == '0)
		else $error("resume did not clear mark count");

	// Edges are dropped while a frame is held
	a_hold_frame: assert property (@(posedge clk) disable iff (!arst_n)
		go && kind == KIND_EDGE && mark_q == FRAME_M
		|=> $stable(prev_q) && $stable(code_q) && mark_q == FRAME_M)
		else $error("held frame disturbed by edge");

endmodule

/* src/ir_pulse_distance_decoder_core.sv */
// Top level of the IR pulse-distance frame decoder.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready kind edge_ticks | beat in
//  out     | out_valid out_ready frame_ready frame_code | beat out
//  cfg     | cfg_we cfg_index cfg_wdata       | write only
//
// One beat per cycle while the result register is not stalled; each beat goes into
// the input register, then the result register. The rate is set by the state update
// between them: multiply, three window compares and the mark counter.
// Reset clears all control and frame state and loads the default windows.
// A stalled result register holds its beat; the input register keeps taking
// beats as long as the result register is free or being drained.
module ir_pulse_distance_decoder_core #(
	parameter int CODE_BITS    = irpdd_pkg::CODE_BITS_DEF,
	parameter int LEADER_MARKS = irpdd_pkg::LEADER_MARKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [irpdd_pkg::TICK_W-1:0]     edge_ticks,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             frame_ready,
	output logic [irpdd_pkg::CODE_W-1:0]     frame_code,
	input  logic                             cfg_we,
	input  logic [irpdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irpdd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import irpdd_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic              kind_s1;
	logic [TICK_W-1:0] ticks_s1;
	logic              out_valid_q;
	logic              ready_q;
	logic [CODE_W-1:0] code_q;
	logic              adv;
	logic              go;
	logic              ready_d;
	logic [CODE_W-1:0] code_d;

	irpdd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	irpdd_frame #(
		.CODE_BITS    (CODE_BITS),
		.LEADER_MARKS (LEADER_MARKS)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.kind       (kind_s1),
		.edge_ticks (ticks_s1),
		.cfg        (cfg),
		.ready_d    (ready_d),
		.code_d     (code_d)
	);

	// Handshake: stage 1 advances when the result register can take a beat
	assign adv      = !out_valid_q || out_ready;
	assign go       = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			ticks_s1 <= edge_ticks;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ready_q <= ready_d;
			code_q  <= ready_d ? code_d : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_ready = ready_q;
	assign frame_code  = code_q;

	// Code is only shown with a complete frame
	a_code_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ready |-> frame_code == '0)
		else $error("code shown without a ready frame");

	// Input side only stalls with a beat waiting in stage 1
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked beat");

	// A processed beat always lands in the result register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid)
		else $error("processed beat produced no result");

endmodule
